@@ src/lzxd_pkg.sv @@
// shared constants and types for the lzss xor stream decoder
// no dependencies; imported by lzxd_window and the top level
package lzxd_pkg;

    localparam int DEFAULT_WINDOW_BITS = 12;
    localparam int DEFAULT_LIMIT_BITS  = 32;

    localparam logic [7:0] XOR_KEY_RESET = 8'h72;

    // result kinds
    localparam logic [1:0] KIND_BYTE   = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;

    // stream modes
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_COMP   = 2'd1;
    localparam logic [1:0] MODE_STORED = 2'd2;

    // header
    localparam logic [3:0] HEADER_LEN = 4'd8;
    localparam logic [7:0] CHAR_THREE = 8'h33;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;

    // distance of the start write position below the window top
    localparam int WINDOW_START_GAP = 18;

    // window port commands from the sequencer
    typedef struct packed {
        logic clear;
        logic wr_en;
        logic rd_en;
    } win_cmd_t;

endpackage

@@ src/lzss_xor_stream_decoder_top.sv @@
// lzss xor stream decoder: header check, xor, flag/literal/match sequencer
// depends on lzxd_pkg and lzxd_window
//
// channel | direction | handshake          | payload
// s_      | in        | s_tvalid/s_tready  | tdata byte, tuser first, tlast last
// m_      | out       | m_tvalid/m_tready  | tdata byte+count, tuser kind, tlast
// cfg_    | in        | cfg_valid/cfg_ready| cfg_data = xor key
//
// a header, flag or literal word is accepted then decoded when the output
// register is free; a match word adds a read and a data state per copied byte,
// set by the single window read port whose registered read feeds each write;
// a stream-end result adds a tail state; a stall on m_tready holds the sequencer
// reset: key 0x72, window empty (fill count, no clearing pass), idle
// tuser on the input restarts the stream state before the word is decoded
module lzss_xor_stream_decoder_top #(
    parameter int WINDOW_BITS = lzxd_pkg::DEFAULT_WINDOW_BITS,
    parameter int LIMIT_BITS  = lzxd_pkg::DEFAULT_LIMIT_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] out_byte, [39:8] out_count
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // last_of_run
    // key register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import lzxd_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_MREAD  = 3'd2;
    localparam logic [2:0] S_MDATA  = 3'd3;
    localparam logic [2:0] S_TAIL   = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [7:0]             key_reg;
    logic [7:0]             byte_reg, byte_next;
    logic                   lastin_reg, lastin_next;
    logic [8:0]             flag_reg, flag_next;       // pending flags above a marker
    logic [8:0]             low_reg, low_next;         // bit 8: low match word held
    logic [3:0]             hpos_reg, hpos_next;
    logic [1:0]             mode_reg, mode_next;
    logic [LIMIT_BITS-1:0]  limit_reg, limit_next;
    logic [31:0]            count_reg, count_next;
    logic                   stopped_reg, stopped_next;
    logic [1:0]             tail_kind_reg, tail_kind_next;
    logic [WINDOW_BITS-1:0] maddr_reg, maddr_next;     // match read address
    logic [4:0]             rem_reg, rem_next;         // match words left

    // output register
    logic                   m_valid_reg;
    logic [7:0]             m_byte_reg;
    logic [1:0]             m_kind_reg;
    logic [31:0]            m_count_reg;
    logic                   m_last_reg;

    logic                   load;
    logic [7:0]             ld_byte;
    logic [1:0]             ld_kind;
    logic [31:0]            ld_count;
    logic                   ld_last;

    win_cmd_t               win_cmd;
    logic [7:0]             win_wr_data;
    logic [7:0]             win_rd_data;

    logic                   slot_free;
    logic [7:0]             dec;                       // payload after xor
    logic                   hdr_bad;
    logic                   at_limit;
    logic                   near_limit;
    logic [31:0]            limit_ext;
    logic [WINDOW_BITS+11:0] off_wide;

    assign slot_free = !m_valid_reg || m_tready;
    assign dec       = byte_reg ^ key_reg;
    assign hdr_bad   = (hpos_reg == 4'd1 && byte_reg != CHAR_THREE)
                    || (hpos_reg == 4'd2 && byte_reg != CHAR_SEMI)
                    || (hpos_reg == 4'd3 && byte_reg != CHAR_ZERO && byte_reg != CHAR_ONE);
    assign at_limit   = count_reg >= 32'(limit_reg);
    assign near_limit = (33'(count_reg) + 33'd1) >= 33'(limit_reg);
    // limit bytes arrive little-endian in header positions four to seven
    assign limit_ext  = 32'(byte_reg) << {hpos_reg[1:0], 3'b000};
    // 12-bit match offset folded onto the window
    assign off_wide   = {{WINDOW_BITS{1'b0}}, dec[7:4], low_reg[7:0]};

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    lzxd_window #(
        .WINDOW_BITS (WINDOW_BITS)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (win_cmd),
        .wr_data (win_wr_data),
        .rd_addr (maddr_reg),
        .rd_data (win_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        byte_next      = byte_reg;
        lastin_next    = lastin_reg;
        flag_next      = flag_reg;
        low_next       = low_reg;
        hpos_next      = hpos_reg;
        mode_next      = mode_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        stopped_next   = stopped_reg;
        tail_kind_next = tail_kind_reg;
        maddr_next     = maddr_reg;
        rem_next       = rem_reg;
        win_cmd        = '0;
        win_wr_data    = dec;
        load           = 1'b0;
        ld_byte        = 8'h00;
        ld_kind        = KIND_BYTE;
        ld_count       = count_reg;
        ld_last        = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next   = s_tdata;
                    lastin_next = s_tlast;
                    state_next  = S_DECODE;
                    if (s_tuser)
                    begin
                        // new stream
                        win_cmd.clear = 1'b1;
                        flag_next     = '0;
                        low_next      = '0;
                        hpos_next     = '0;
                        mode_next     = MODE_NONE;
                        limit_next    = '0;
                        count_next    = '0;
                        stopped_next  = 1'b0;
                    end
                end
            end

            S_DECODE:
            begin
                if (stopped_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    state_next     = lastin_reg ? S_TAIL : S_IDLE;
                    tail_kind_next = KIND_DONE;
                    if (hpos_reg < HEADER_LEN)
                    begin
                        if (hdr_bad)
                        begin
                            load         = 1'b1;
                            ld_kind      = KIND_REJECT;
                            stopped_next = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            hpos_next = hpos_reg + 4'd1;
                            if (hpos_reg == 4'd3)
                            begin
                                mode_next = (byte_reg == CHAR_ONE) ? MODE_COMP : MODE_STORED;
                            end
                            if (hpos_reg >= 4'd4)
                            begin
                                limit_next = limit_reg | limit_ext[LIMIT_BITS-1:0];
                            end
                            // a stream that ends before the mode byte is rejected
                            if (hpos_reg <= 4'd2)
                            begin
                                tail_kind_next = KIND_REJECT;
                            end
                        end
                    end
                    else if (mode_reg == MODE_COMP)
                    begin
                        if (low_reg[8])
                        begin
                            low_next   = '0;
                            flag_next  = flag_reg >> 1;
                            maddr_next = off_wide[WINDOW_BITS-1:0];
                            rem_next   = 5'(dec[3:0]) + 5'd3;
                            state_next = S_MREAD;
                        end
                        else if (flag_reg <= 9'd1)
                        begin
                            flag_next = {1'b1, dec};
                        end
                        else if (flag_reg[0])
                        begin
                            flag_next = flag_reg >> 1;
                            load      = 1'b1;
                            if (at_limit)
                            begin
                                ld_kind      = KIND_DONE;
                                stopped_next = 1'b1;
                                state_next   = S_IDLE;
                            end
                            else
                            begin
                                ld_byte       = dec;
                                ld_count      = count_reg + 32'd1;
                                ld_last       = !lastin_reg;
                                count_next    = count_reg + 32'd1;
                                win_cmd.wr_en = 1'b1;
                            end
                        end
                        else
                        begin
                            low_next = {1'b1, dec};
                        end
                    end
                    else
                    begin
                        // stored mode
                        load = 1'b1;
                        if (at_limit)
                        begin
                            ld_kind      = KIND_DONE;
                            stopped_next = 1'b1;
                            state_next   = S_IDLE;
                        end
                        else
                        begin
                            ld_byte    = dec;
                            ld_count   = count_reg + 32'd1;
                            ld_last    = !lastin_reg;
                            count_next = count_reg + 32'd1;
                        end
                    end
                end
            end

            S_MREAD:
            begin
                win_cmd.rd_en = 1'b1;
                state_next    = S_MDATA;
            end

            S_MDATA:
            begin
                if (at_limit)
                begin
                    // rest of the match is dropped
                    state_next = lastin_reg ? S_TAIL : S_IDLE;
                end
                else if (slot_free)
                begin
                    load          = 1'b1;
                    ld_byte       = win_rd_data;
                    ld_count      = count_reg + 32'd1;
                    count_next    = count_reg + 32'd1;
                    win_cmd.wr_en = 1'b1;
                    win_wr_data   = win_rd_data;
                    maddr_next    = maddr_reg + 1'b1;
                    rem_next      = rem_reg - 5'd1;
                    if (rem_reg == 5'd1 || near_limit)
                    begin
                        ld_last    = !lastin_reg;
                        state_next = lastin_reg ? S_TAIL : S_IDLE;
                    end
                    else
                    begin
                        ld_last    = 1'b0;
                        state_next = S_MREAD;
                    end
                end
            end

            S_TAIL:
            begin
                if (slot_free)
                begin
                    load         = 1'b1;
                    ld_kind      = tail_kind_reg;
                    stopped_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            key_reg       <= XOR_KEY_RESET;
            flag_reg      <= '0;
            low_reg       <= '0;
            hpos_reg      <= '0;
            mode_reg      <= MODE_NONE;
            limit_reg     <= '0;
            count_reg     <= '0;
            stopped_reg   <= 1'b0;
            tail_kind_reg <= KIND_DONE;
            rem_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            flag_reg      <= flag_next;
            low_reg       <= low_next;
            hpos_reg      <= hpos_next;
            mode_reg      <= mode_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            stopped_reg   <= stopped_next;
            tail_kind_reg <= tail_kind_next;
            rem_reg       <= rem_next;
            if (cfg_valid && cfg_ready)
            begin
                key_reg <= cfg_data;
            end
            if (load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        lastin_reg <= lastin_next;
        maddr_reg  <= maddr_next;
        if (load)
        begin
            m_byte_reg  <= ld_byte;
            m_kind_reg  <= ld_kind;
            m_count_reg <= ld_count;
            m_last_reg  <= ld_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_byte_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    // end-of-stream and reject results always close the run
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != KIND_BYTE) |-> m_tlast)
        else $error("non-byte result without last flag");

    // a match in flight always has words left
    a_match_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MREAD || state_reg == S_MDATA) |-> (rem_reg != 5'd0))
        else $error("match copy with no words left");

    // every window write is also a decoded byte result
    a_write_emits: assert property (@(posedge clk) disable iff (!rst_n)
        win_cmd.wr_en |-> (load && ld_kind == KIND_BYTE))
        else $error("window written without a byte result");

    // a decoded byte is never emitted past the output limit
    a_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (load && ld_kind == KIND_BYTE) |-> !at_limit)
        else $error("byte emitted at or past the limit");

    // the sequencer only leaves idle through an accepted word
    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !s_tvalid) |=> (state_reg == S_IDLE))
        else $error("sequencer left idle without input");
`endif

endmodule

@@ src/lzxd_window.sv @@
// history window memory with write pointer, fill count and registered read
// depends on lzxd_pkg (win_cmd_t, WINDOW_START_GAP, default window size)
module lzxd_window #(
    parameter int WINDOW_BITS = lzxd_pkg::DEFAULT_WINDOW_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lzxd_pkg::win_cmd_t     cmd,
    input  logic [7:0]             wr_data,
    input  logic [WINDOW_BITS-1:0] rd_addr,
    output logic [7:0]             rd_data
);
    import lzxd_pkg::*;

    localparam int WSIZE = 1 << WINDOW_BITS;
    localparam logic [WINDOW_BITS-1:0] WSTART = WINDOW_BITS'(WSIZE - WINDOW_START_GAP);
    localparam logic [WINDOW_BITS:0]   FILL_FULL = (WINDOW_BITS+1)'(WSIZE);

    logic [7:0]             mem [WSIZE];
    logic [WINDOW_BITS-1:0] wpos_reg, wpos_next;
    logic [WINDOW_BITS:0]   fill_reg, fill_next;
    logic [7:0]             rd_data_reg;
    logic                   rd_valid_reg;
    logic [WINDOW_BITS-1:0] rd_dist;

    // entries are written in order from the start position, so an entry was
    // written this stream exactly when its distance from the start is below fill
    assign rd_dist = rd_addr - WSTART;

    always_comb
    begin
        wpos_next = wpos_reg;
        fill_next = fill_reg;
        if (cmd.clear)
        begin
            wpos_next = WSTART;
            fill_next = '0;
        end
        else if (cmd.wr_en)
        begin
            wpos_next = wpos_reg + 1'b1;
            if (fill_reg != FILL_FULL)
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg     <= WSTART;
            fill_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            wpos_reg <= wpos_next;
            fill_reg <= fill_next;
            if (cmd.rd_en)
            begin
                rd_valid_reg <= ({1'b0, rd_dist} < fill_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !cmd.clear)
        begin
            mem[wpos_reg] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // unwritten entries read as zero
    assign rd_data = rd_valid_reg ? rd_data_reg : 8'h00;

endmodule
